// ----- sv/hcs_pkg.sv -----
`timescale 1ns / 1ps
package hcs_pkg;

  typedef enum logic [1:0] {
    CMD_GET = 2'd0,
    CMD_SET = 2'd1,
    CMD_INC = 2'd2,
    CMD_DEL = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH1,
    ST_HASH2,
    ST_MOD,
    ST_HEAD,
    ST_RD,
    ST_CMP,
    ST_ACT,
    ST_FREE,
    ST_FREE2,
    ST_OUT
  } state_t;

  localparam logic [31:0] KEY_MULT = 32'd1999;

  // Control to the remainder unit.
  typedef struct packed {
    logic start;
  } mod_ctl_t;

endpackage

// ----- sv/hashed_cell_key_value_store.sv -----
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// in      | sink      | in_tvalid / in_tready  | cmd, key_x, key_y, key_gen, write_value
// out     | source    | out_tvalid / out_tready| read_value, found, status
// cfg     | sink      | cfg_valid / cfg_ready  | hash_size
// One request at a time: the accept cycle and ST_HASH1 each do one hash multiply, ST_HASH2
// starts the bit-serial remainder unit, then a head read, an entry read and a compare per
// chain entry visited, one more read at the chain end on a miss, an update step, ST_FREE and
// ST_FREE2 when a delete frees an entry, and an output step. Reset clears bucket heads
// through per-bucket valid bits; no clearing pass. The result is held until out_tready
// takes it, and in_tready stays low until then.
module hashed_cell_key_value_store import hcs_pkg::*; #(
  parameter int BUCKETS    = 256,
  parameter int ENTRIES    = 1024,
  parameter int COORD_BITS = 16,
  parameter int GEN_BITS   = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // cmd[1:0], key_x, key_y, key_gen, write_value, zero fill
  input  logic [((2+2*COORD_BITS+GEN_BITS+VALUE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // read_value, found, status, zero fill
  output logic [((VALUE_BITS+2+7)/8)*8-1:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [8:0] cfg_data
);

  localparam int OW   = ((VALUE_BITS+2+7)/8)*8;
  localparam int EB   = $clog2(ENTRIES);
  localparam int PB   = EB + 1;
  localparam int BB   = $clog2(BUCKETS);
  localparam int HB   = $clog2(BUCKETS + 1);
  localparam int KB   = 2*COORD_BITS + GEN_BITS;
  localparam logic [PB-1:0] NIL = PB'(ENTRIES);
  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  state_t state_r, state_nxt;

  logic [8:0]            hsize_r;
  logic [1:0]            cmd_r;
  logic [KB-1:0]         key_r;
  logic [VALUE_BITS-1:0] wv_r;
  logic [31:0]           h_r;
  logic [BB-1:0]         bkt_r;
  logic [PB-1:0]         cur_r, prev_r, free_r, fresh_r;
  logic [PB-1:0]         steps_r;
  logic [VALUE_BITS-1:0] rv_r;
  logic                  found_r, st_r;
  logic                  ov_r;

  // Bucket heads with valid bits, entry memories.
  logic [PB-1:0]         heads [BUCKETS];
  logic [BUCKETS-1:0]    hvld_r;
  logic [KB-1:0]         ekey [ENTRIES];
  logic [VALUE_BITS-1:0] eval [ENTRIES];
  logic [PB-1:0]         elink [ENTRIES];
  logic [KB-1:0]         rkey_r;
  logic [VALUE_BITS-1:0] rval_r;
  logic [PB-1:0]         rlink_r;
  logic [PB-1:0]         rlink_free;

  logic [COORD_BITS-1:0] kx, ky;
  logic [GEN_BITS-1:0]   kg;
  logic [31:0]           xs, ys;
  logic [HB-1:0]         hclip;
  logic [HB-1:0]         div;
  logic [HB-1:0]         rem;
  logic                  mdone;
  mod_ctl_t              mctl;

  // The first hash step works on the incoming item; the generation comes from the key.
  assign kx = in_tdata[COORD_BITS+1:2];
  assign ky = in_tdata[2*COORD_BITS+1:COORD_BITS+2];
  assign kg = key_r[KB-1:2*COORD_BITS];
  assign xs = 32'(signed'(kx));
  assign ys = 32'(signed'(ky));

  // Effective bucket count: zero acts as one, clipped to the table size.
  always_comb begin
    if (hsize_r == 9'd0) div = HB'(1);
    else if ({23'd0, hsize_r} > BUCKETS) div = HB'(BUCKETS);
    else div = HB'(hsize_r);
  end
  assign hclip = div;

  assign mctl.start = (state_r == ST_HASH2);

  hcs_mod #(.DBITS(HB)) u_mod (
    .clk(clk), .rst_n(rst_n), .ctl(mctl), .hash(h_r),
    .divisor(hclip), .done(mdone), .rem(rem)
  );

  logic hit;
  assign hit = (rkey_r == key_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid && in_tready) state_nxt = ST_HASH1;
      ST_HASH1: state_nxt = ST_HASH2;
      ST_HASH2: state_nxt = ST_MOD;
      ST_MOD:   if (mdone) state_nxt = ST_HEAD;
      ST_HEAD:  state_nxt = ST_RD;
      ST_RD:    state_nxt = (cur_r >= NIL || steps_r >= NIL) ? ST_ACT : ST_CMP;
      ST_CMP:   state_nxt = hit ? ST_ACT : ST_RD;
      ST_ACT:   state_nxt = (cmd_r == CMD_DEL && found_r) ? ST_FREE : ST_OUT;
      ST_FREE:  state_nxt = ST_FREE2;
      ST_FREE2: state_nxt = ST_OUT;
      ST_OUT:   if (out_tready || !ov_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_tready = (state_r == ST_IDLE) && !ov_r;
    cfg_ready = (state_r == ST_IDLE) && !ov_r;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OW'({st_r, found_r, rv_r});

  logic [PB-1:0]         newe;
  logic                  canal;
  always_comb begin
    canal = (free_r < NIL) || (fresh_r < NIL);
    newe  = (free_r < NIL) ? free_r : fresh_r;
  end

  // Datapath and memories.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd_r   <= in_tdata[1:0];
          key_r   <= in_tdata[KB+1:2];
          wv_r    <= in_tdata[KB+VALUE_BITS+1:KB+2];
          h_r     <= xs * KEY_MULT + ys;
          found_r <= 1'b0;
          st_r    <= 1'b0;
          rv_r    <= '0;
        end
      end
      ST_HASH1: h_r <= h_r * KEY_MULT + 32'(kg);
      ST_MOD: begin
        bkt_r   <= BB'(rem);
        steps_r <= '0;
        prev_r  <= NIL;
      end
      ST_HEAD: cur_r <= hvld_r[bkt_r] ? heads[bkt_r] : NIL;
      ST_RD: begin
        if (cur_r < NIL && steps_r < NIL) begin
          rkey_r  <= ekey[cur_r[EB-1:0]];
          rval_r  <= eval[cur_r[EB-1:0]];
          rlink_r <= elink[cur_r[EB-1:0]];
        end
      end
      ST_CMP: begin
        if (hit) found_r <= 1'b1;
        else begin
          prev_r  <= cur_r;
          cur_r   <= rlink_r;
          steps_r <= steps_r + PB'(1);
        end
      end
      ST_ACT: begin
        case (cmd_r)
          CMD_GET: if (found_r) rv_r <= rval_r;
          CMD_SET, CMD_INC: begin
            if (found_r) begin
              if (cmd_r == CMD_SET) begin
                eval[cur_r[EB-1:0]] <= wv_r;
                rv_r <= wv_r;
              end else begin
                eval[cur_r[EB-1:0]] <= (rval_r == VMAX) ? rval_r : rval_r + 1'b1;
                rv_r <= (rval_r == VMAX) ? rval_r : rval_r + 1'b1;
              end
            end else if (!canal) begin
              st_r <= 1'b1;
            end else begin
              ekey[newe[EB-1:0]]  <= key_r;
              elink[newe[EB-1:0]] <= NIL;
              eval[newe[EB-1:0]]  <= (cmd_r == CMD_SET) ? wv_r : VALUE_BITS'(1);
              rv_r <= (cmd_r == CMD_SET) ? wv_r : VALUE_BITS'(1);
              if (prev_r < NIL) elink[prev_r[EB-1:0]] <= newe;
              else heads[bkt_r] <= newe;
            end
          end
          default: begin
            if (found_r) begin
              if (prev_r < NIL) elink[prev_r[EB-1:0]] <= rlink_r;
              else heads[bkt_r] <= rlink_r;
            end
          end
        endcase
      end
      ST_FREE: elink[cur_r[EB-1:0]] <= free_r;
      default: ;
    endcase
  end

  // Control registers: state, hash size, free list, fresh count, bucket valid bits, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hsize_r <= 9'd256;
      free_r  <= NIL;
      fresh_r <= '0;
      hvld_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) hsize_r <= cfg_data;
      if (state_r == ST_ACT && (cmd_r == CMD_SET || cmd_r == CMD_INC) && !found_r
          && canal) begin
        if (free_r < NIL) free_r <= rlink_free;
        else fresh_r <= fresh_r + PB'(1);
        if (prev_r >= NIL) hvld_r[bkt_r] <= 1'b1;
      end
      if (state_r == ST_ACT && cmd_r == CMD_DEL && found_r && prev_r >= NIL)
        hvld_r[bkt_r] <= 1'b1;
      if (state_r == ST_FREE) free_r <= cur_r;
      if (state_r == ST_OUT && !ov_r) ov_r <= 1'b1;
      else if (ov_r && out_tready) ov_r <= 1'b0;
    end
  end

  // Link of the free-list head, read while idle work runs.
  always_ff @(posedge clk) begin
    if (free_r < NIL) rlink_free <= (elink[free_r[EB-1:0]] < NIL) ?
                                    elink[free_r[EB-1:0]] : NIL;
  end

endmodule

// ----- sv/hcs_mod.sv -----
`timescale 1ns / 1ps
// Bit-serial non-negative remainder of a signed 32-bit hash by a divisor.
module hcs_mod import hcs_pkg::*; #(
  parameter int DBITS = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mod_ctl_t         ctl,
  input  logic [31:0]      hash,
  input  logic [DBITS-1:0] divisor,
  output logic             done,
  output logic [DBITS-1:0] rem
);

  logic [31:0]      mag_r, mag_nxt;
  logic [DBITS:0]   rem_r, rem_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DBITS:0]   shifted;
  logic [DBITS:0]   fixed;

  // One quotient bit per cycle; a negative dividend is corrected at the end.
  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[DBITS-1:0], mag_r[31]};
    fixed    = '0;
    if (ctl.start) begin
      mag_nxt  = hash[31] ? (~hash + 32'd1) : hash;
      neg_nxt  = hash[31];
      rem_nxt  = '0;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (neg_r && rem_r != '0) begin
          fixed   = {1'b0, divisor} - rem_r;
          rem_nxt = fixed;
        end
      end else begin
        mag_nxt = {mag_r[30:0], 1'b0};
        rem_nxt = (shifted >= {1'b0, divisor}) ? shifted - {1'b0, divisor} : shifted;
        cnt_nxt = cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[DBITS-1:0];

endmodule
